### hdl/deq_pkg.sv
package deq_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int VALUE_W       = 32;
    localparam int CMD_W         = 3;

    localparam logic [CMD_W-1:0] CMD_PUSH_REAR  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_REAR   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd4;
    localparam logic [CMD_W-1:0] CMD_QUERY      = 3'd5;

    localparam logic [VALUE_W-1:0] INT_MIN = 32'h8000_0000;

    typedef struct packed {
        logic capture;
        logic exec;
        logic read;
        logic load;
    } deq_ctl_t;

endpackage

### hdl/deq_ctrl.sv
module deq_ctrl
    import deq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    output deq_ctl_t ctl
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_READ = 2'd2;
    localparam logic [1:0] S_LOAD = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       load_ok;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign load_ok   = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next  = state_reg;
        ctl         = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                ctl.exec   = 1'b1;
                state_next = S_READ;
            end
            S_READ:
            begin
                ctl.read   = 1'b1;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                if (load_ok)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctl.load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### hdl/deq_datapath.sv
module deq_datapath
    import deq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT,
    parameter int CNT_W = $clog2(DEPTH + 1)
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  deq_ctl_t           ctl,
    input  logic [CMD_W-1:0]   in_command,
    input  logic [VALUE_W-1:0] in_value,
    output logic [VALUE_W-1:0] front_value,
    output logic [VALUE_W-1:0] rear_value,
    output logic [CNT_W-1:0]   count,
    output logic               is_empty,
    output logic               dropped
);

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int SUM_W  = CNT_W + 1;
    localparam logic [SUM_W-1:0]  DEPTH_S = SUM_W'(DEPTH);
    localparam logic [CNT_W-1:0]  DEPTH_C = CNT_W'(DEPTH);
    localparam logic [ADDR_W-1:0] LAST_A  = ADDR_W'(DEPTH - 1);

    logic [VALUE_W-1:0] mem [DEPTH];

    logic [CMD_W-1:0]   cmd_reg;
    logic [VALUE_W-1:0] value_reg;
    logic [ADDR_W-1:0]  head_reg;
    logic [ADDR_W-1:0]  head_next;
    logic [CNT_W-1:0]   fill_reg;
    logic [CNT_W-1:0]   fill_next;
    logic               drop_reg;
    logic               drop_next;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [VALUE_W-1:0] front_rd_reg;
    logic [VALUE_W-1:0] rear_rd_reg;
    logic [VALUE_W-1:0] front_out_reg;
    logic [VALUE_W-1:0] rear_out_reg;
    logic [CNT_W-1:0]   count_out_reg;
    logic               empty_out_reg;
    logic               drop_out_reg;

    logic               full;
    logic [SUM_W-1:0]   head_ext;
    logic [SUM_W-1:0]   fill_ext;
    logic [ADDR_W-1:0]  tail_addr;
    logic [ADDR_W-1:0]  rear_addr;
    logic [ADDR_W-1:0]  head_dec;
    logic [ADDR_W-1:0]  head_inc;

    function automatic logic [ADDR_W-1:0] wrap_sum(input logic [SUM_W-1:0] s);
        logic [SUM_W-1:0] r;
        if (s >= DEPTH_S)
        begin
            r = s - DEPTH_S;
        end
        else
        begin
            r = s;
        end
        return r[ADDR_W-1:0];
    endfunction

    assign full      = (fill_reg == DEPTH_C);
    assign head_ext  = SUM_W'(head_reg);
    assign fill_ext  = SUM_W'(fill_reg);
    assign tail_addr = wrap_sum(head_ext + fill_ext);
    assign rear_addr = wrap_sum(head_ext + fill_ext - SUM_W'(1));
    assign head_dec  = (head_reg == '0) ? LAST_A : head_reg - ADDR_W'(1);
    assign head_inc  = (head_reg == LAST_A) ? '0 : head_reg + ADDR_W'(1);

    always_comb
    begin
        head_next = head_reg;
        fill_next = fill_reg;
        drop_next = 1'b0;
        wr_en     = 1'b0;
        wr_addr   = tail_addr;
        case (cmd_reg)
            CMD_PUSH_REAR:
            begin
                if (full)
                begin
                    drop_next = 1'b1;
                end
                else
                begin
                    wr_en     = 1'b1;
                    fill_next = fill_reg + CNT_W'(1);
                end
            end
            CMD_PUSH_FRONT:
            begin
                if (full)
                begin
                    drop_next = 1'b1;
                end
                else
                begin
                    wr_en     = 1'b1;
                    wr_addr   = head_dec;
                    head_next = head_dec;
                    fill_next = fill_reg + CNT_W'(1);
                end
            end
            CMD_POP_REAR:
            begin
                if (fill_reg != '0)
                begin
                    fill_next = fill_reg - CNT_W'(1);
                end
            end
            CMD_POP_FRONT:
            begin
                if (fill_reg != '0)
                begin
                    head_next = head_inc;
                    fill_next = fill_reg - CNT_W'(1);
                end
            end
            CMD_CLEAR:
            begin
                head_next = '0;
                fill_next = '0;
            end
            CMD_QUERY:
            begin
                head_next = head_reg;
            end
            default:
            begin
                head_next = head_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            fill_reg <= '0;
        end
        else if (ctl.exec)
        begin
            head_reg <= head_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            cmd_reg   <= in_command;
            value_reg <= in_value;
        end
        if (ctl.exec)
        begin
            drop_reg <= drop_next;
        end
    end

    // one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (ctl.exec && wr_en)
        begin
            mem[wr_addr] <= value_reg;
        end
        if (ctl.read)
        begin
            front_rd_reg <= mem[head_reg];
            rear_rd_reg  <= mem[rear_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            front_out_reg <= (fill_reg == '0) ? INT_MIN : front_rd_reg;
            rear_out_reg  <= (fill_reg == '0) ? INT_MIN : rear_rd_reg;
            count_out_reg <= fill_reg;
            empty_out_reg <= (fill_reg == '0);
            drop_out_reg  <= drop_reg;
        end
    end

    assign front_value = front_out_reg;
    assign rear_value  = rear_out_reg;
    assign count       = count_out_reg;
    assign is_empty    = empty_out_reg;
    assign dropped     = drop_out_reg;

endmodule

### hdl/double_ended_queue_top.sv
// bounded double-ended queue of signed 32-bit values in a circular buffer
// slave channel: one command per transaction, tuser = command, tdata = value
// commands: push rear, push front, pop rear, pop front, clear, query
// (unused codes behave as query)
// master channel: one result transaction per command, giving front and rear
// values after the operation, the count, an empty flag and a dropped flag
// an empty queue reports the most negative value for front and rear
// a push on a full queue is dropped and flagged, a pop on an empty one ignored
// the result is valid once the command has passed the controller sequence
// and a new command is taken only after the previous one is loaded; the sequence:
// capture, update and write, registered slot read, result load
// the output register holds a result while the next command is taken
// if the receiver stalls, the load step waits until the output register frees
// reset empties the queue (head and count to zero) and drops any pending result
// slot contents are not cleared and never reach the output before being written
module double_ended_queue_top
    import deq_pkg::*;
#(
    parameter int DEPTH   = DEPTH_DEFAULT,
    parameter int CNT_W   = $clog2(DEPTH + 1),
    parameter int TDATA_W = ((2 * VALUE_W + CNT_W + 7) / 8) * 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [VALUE_W-1:0] s_tdata,   // value
    input  logic [CMD_W-1:0]   s_tuser,   // command
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // front_value, rear_value, count
    output logic [1:0]         m_tuser    // is_empty, dropped
);

    deq_ctl_t           ctl;
    logic [VALUE_W-1:0] front_value;
    logic [VALUE_W-1:0] rear_value;
    logic [CNT_W-1:0]   count;
    logic               is_empty;
    logic               dropped;

    deq_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .ctl       (ctl)
    );

    deq_datapath #(
        .DEPTH (DEPTH),
        .CNT_W (CNT_W)
    ) u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .in_command  (s_tuser),
        .in_value    (s_tdata),
        .front_value (front_value),
        .rear_value  (rear_value),
        .count       (count),
        .is_empty    (is_empty),
        .dropped     (dropped)
    );

    assign m_tdata = TDATA_W'({count, rear_value, front_value});
    assign m_tuser = {dropped, is_empty};

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("command taken while another is in progress");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (is_empty == (count == '0)))
        else $error("empty flag disagrees with count");

    a_empty_values: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && is_empty |-> (front_value == INT_MIN) && (rear_value == INT_MIN))
        else $error("empty result without most negative front and rear");

    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && dropped |-> (count == CNT_W'(DEPTH)))
        else $error("push dropped while queue not full");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (count <= CNT_W'(DEPTH)))
        else $error("count exceeds depth");

endmodule

### dv/tb.sv
`timescale 1ns / 1ps

module tb;
    import deq_pkg::*;

    localparam int QDEPTH   = DEPTH_DEFAULT;
    localparam int TDATA_W  = 72;
    localparam int N_RANDOM = 620;
    localparam int N_DIR    = 21;
    localparam int LIMIT    = 300000;

    localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [VALUE_W-1:0] front;
        logic [VALUE_W-1:0] rear;
        logic [4:0]         count;
        logic               empty;
        logic               dropped;
    } deq_result_t;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [VALUE_W-1:0] value;
        logic [4:0]         reps;
        logic               typed;
        deq_result_t        res;
    } stim_row_t;

    localparam deq_result_t RES_EMPTY = '{INT_MIN, INT_MIN, 5'd0, 1'b1, 1'b0};
    localparam deq_result_t RES_NONE  = '0;

    // pushes with several repeats use value, value + 1, ...
    localparam stim_row_t DIR_TAB [N_DIR] = '{
        '{CMD_QUERY,      32'h0000_0000, 5'd1,  1'b1, RES_EMPTY},
        '{CMD_POP_REAR,   32'hFFFF_FFFF, 5'd1,  1'b1, RES_EMPTY},
        '{CMD_POP_FRONT,  32'h1234_5678, 5'd1,  1'b1, RES_EMPTY},
        '{CMD_PUSH_REAR,  32'h7FFF_FFFF, 5'd1,  1'b1,
          '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 5'd1, 1'b0, 1'b0}},
        '{CMD_PUSH_FRONT, 32'h8000_0000, 5'd1,  1'b1,
          '{32'h8000_0000, 32'h7FFF_FFFF, 5'd2, 1'b0, 1'b0}},
        '{CMD_POP_REAR,   32'h0000_0000, 5'd1,  1'b1,
          '{32'h8000_0000, 32'h8000_0000, 5'd1, 1'b0, 1'b0}},
        '{CMD_CLEAR,      32'hA5A5_A5A5, 5'd1,  1'b1, RES_EMPTY},
        '{CMD_PUSH_FRONT, 32'h0000_0000, 5'd1,  1'b1,
          '{32'h0000_0000, 32'h0000_0000, 5'd1, 1'b0, 1'b0}},
        '{CMD_SPARE_6,    32'h0000_0005, 5'd1,  1'b1,
          '{32'h0000_0000, 32'h0000_0000, 5'd1, 1'b0, 1'b0}},
        '{CMD_SPARE_7,    32'hFFFF_FFFF, 5'd1,  1'b1,
          '{32'h0000_0000, 32'h0000_0000, 5'd1, 1'b0, 1'b0}},
        '{CMD_PUSH_FRONT, 32'h0000_0100, 5'd8,  1'b0, RES_NONE},
        '{CMD_PUSH_REAR,  32'h0000_0200, 5'd7,  1'b0, RES_NONE},
        '{CMD_PUSH_REAR,  32'hFFFF_FFFF, 5'd1,  1'b0, RES_NONE},
        '{CMD_PUSH_FRONT, 32'h0000_0001, 5'd1,  1'b0, RES_NONE},
        '{CMD_QUERY,      32'h0000_0000, 5'd1,  1'b0, RES_NONE},
        '{CMD_POP_FRONT,  32'h0000_0000, 5'd10, 1'b0, RES_NONE},
        '{CMD_PUSH_REAR,  32'h0000_0300, 5'd10, 1'b0, RES_NONE},
        '{CMD_POP_REAR,   32'h0000_0000, 5'd16, 1'b0, RES_NONE},
        '{CMD_POP_REAR,   32'h0000_0000, 5'd1,  1'b1, RES_EMPTY},
        '{CMD_PUSH_REAR,  32'h5555_AAAA, 5'd1,  1'b1,
          '{32'h5555_AAAA, 32'h5555_AAAA, 5'd1, 1'b0, 1'b0}},
        '{CMD_CLEAR,      32'h0000_0000, 5'd1,  1'b1, RES_EMPTY}
    };

    logic               clk      = 1'b0;
    logic               rst_n    = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [VALUE_W-1:0] s_tdata  = '0;
    logic [CMD_W-1:0]   s_tuser  = CMD_QUERY;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [TDATA_W-1:0] m_tdata;
    logic [1:0]         m_tuser;

    logic [VALUE_W-1:0] slot_mem [QDEPTH];
    logic [3:0]         head_idx = '0;
    logic [4:0]         fill_cnt = '0;

    deq_result_t expected_q [$];
    int          errors    = 0;
    int          sent_cnt  = 0;
    int          burst_left = 0;
    longint      cycles    = 0;

    double_ended_queue_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycles, msg);
        errors++;
    endtask

    function automatic deq_result_t apply_cmd(input logic [CMD_W-1:0] cmd,
                                              input logic [VALUE_W-1:0] val);
        deq_result_t r;
        logic [3:0]  idx;
        r.dropped = 1'b0;
        case (cmd)
            CMD_PUSH_REAR:
                if (fill_cnt == QDEPTH)
                    r.dropped = 1'b1;
                else
                begin
                    idx = head_idx + fill_cnt[3:0];
                    slot_mem[idx] = val;
                    fill_cnt++;
                end
            CMD_PUSH_FRONT:
                if (fill_cnt == QDEPTH)
                    r.dropped = 1'b1;
                else
                begin
                    head_idx = head_idx - 4'd1;
                    slot_mem[head_idx] = val;
                    fill_cnt++;
                end
            CMD_POP_REAR:
                if (fill_cnt != 0)
                    fill_cnt--;
            CMD_POP_FRONT:
                if (fill_cnt != 0)
                begin
                    head_idx = head_idx + 4'd1;
                    fill_cnt--;
                end
            CMD_CLEAR:
            begin
                head_idx = '0;
                fill_cnt = '0;
            end
            default: ;
        endcase
        if (fill_cnt != 0)
        begin
            idx     = head_idx + fill_cnt[3:0] - 4'd1;
            r.front = slot_mem[head_idx];
            r.rear  = slot_mem[idx];
        end
        else
        begin
            r.front = INT_MIN;
            r.rear  = INT_MIN;
        end
        r.count = fill_cnt;
        r.empty = (fill_cnt == 0);
        return r;
    endfunction

    task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [VALUE_W-1:0] val,
                            input logic typed, input deq_result_t typed_res);
        deq_result_t r;
        int          gap;
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= val;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        r = apply_cmd(cmd, val);
        expected_q.push_back(typed ? typed_res : r);
        sent_cnt++;
        if (burst_left == 0)
        begin
            gap        = $urandom_range(0, 6);
            burst_left = $urandom_range(1, 24);
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap)
                    @(posedge clk);
            end
        end
        else
            burst_left--;
    endtask

    function automatic logic [CMD_W-1:0] pick_cmd(input int mode);
        int r;
        r = $urandom_range(0, 99);
        if (mode == 3)
            return CMD_W'($urandom_range(0, 7));
        if (mode == 0)
        begin
            if (r < 40) return CMD_PUSH_REAR;
            if (r < 80) return CMD_PUSH_FRONT;
            if (r < 88) return CMD_POP_REAR;
            if (r < 96) return CMD_POP_FRONT;
        end
        else if (mode == 1)
        begin
            if (r < 10) return CMD_PUSH_REAR;
            if (r < 20) return CMD_PUSH_FRONT;
            if (r < 55) return CMD_POP_REAR;
            if (r < 90) return CMD_POP_FRONT;
        end
        else
        begin
            if (r < 25) return CMD_PUSH_REAR;
            if (r < 50) return CMD_PUSH_FRONT;
            if (r < 70) return CMD_POP_REAR;
            if (r < 90) return CMD_POP_FRONT;
        end
        case ($urandom_range(0, 3))
            0:       return CMD_CLEAR;
            1:       return CMD_QUERY;
            2:       return CMD_SPARE_6;
            default: return CMD_SPARE_7;
        endcase
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 19))
            0:       return INT_MIN;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    // result checking
    always @(posedge clk)
    begin
        deq_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_q.size() == 0)
                report_mismatch($sformatf("result with nothing expected, tdata %h", m_tdata));
            else
            begin
                want = expected_q.pop_front();
                if (m_tdata[31:0] !== want.front)
                    report_mismatch($sformatf("front %h, want %h", m_tdata[31:0], want.front));
                if (m_tdata[63:32] !== want.rear)
                    report_mismatch($sformatf("rear %h, want %h", m_tdata[63:32], want.rear));
                if (m_tdata[68:64] !== want.count)
                    report_mismatch($sformatf("count %0d, want %0d", m_tdata[68:64],
                                              want.count));
                if (m_tuser[0] !== want.empty)
                    report_mismatch($sformatf("is_empty %b, want %b", m_tuser[0], want.empty));
                if (m_tuser[1] !== want.dropped)
                    report_mismatch($sformatf("dropped %b, want %b", m_tuser[1],
                                              want.dropped));
            end
        end
    end

    // receiver stall pattern, with one long hold-off to back the block up
    initial
    begin
        int mode;
        int len;
        bit held;
        held = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!held && sent_cnt >= 200)
            begin
                held = 1'b1;
                repeat (120)
                begin
                    @(posedge clk);
                    m_tready <= 1'b0;
                end
            end
            else
            begin
                mode = $urandom_range(0, 3);
                len  = $urandom_range(10, 60);
                for (int i = 0; i < len; i++)
                begin
                    @(posedge clk);
                    case (mode)
                        0:       m_tready <= 1'b1;
                        1:       m_tready <= 1'($urandom_range(0, 1));
                        2:       m_tready <= ((i % 5) < 3);
                        default: m_tready <= ($urandom_range(0, 9) != 0);
                    endcase
                end
            end
        end
    end

    initial
    begin
        logic [VALUE_W-1:0] v;
        logic [CMD_W-1:0]   c;
        int                 mode;
        int                 len;
        int                 n;
        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIR; i++)
        begin
            for (int k = 0; k < DIR_TAB[i].reps; k++)
            begin
                v = DIR_TAB[i].value;
                if (DIR_TAB[i].cmd == CMD_PUSH_REAR || DIR_TAB[i].cmd == CMD_PUSH_FRONT)
                    v = v + k;
                send_cmd(DIR_TAB[i].cmd, v, DIR_TAB[i].typed, DIR_TAB[i].res);
            end
        end

        // runs biased towards filling, draining, balanced use or any code
        n = 0;
        while (n < N_RANDOM)
        begin
            mode = $urandom_range(0, 3);
            len  = $urandom_range(4, 40);
            repeat (len)
            begin
                c = pick_cmd(mode);
                v = pick_value();
                send_cmd(c, v, 1'b0, RES_NONE);
                n++;
            end
        end
        s_tvalid <= 1'b0;

        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (10)
            @(posedge clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

### files.f
hdl/deq_pkg.sv
hdl/deq_ctrl.sv
hdl/deq_datapath.sv
hdl/double_ended_queue_top.sv
dv/tb.sv
